### sv/dtl_pkg.sv
`default_nettype none

package dtl_pkg;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_IDENT   = 3'd1,
        M_NUMBER  = 3'd2,
        M_EQUAL   = 3'd3,
        M_SLASH   = 3'd4,
        M_COMMENT = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        K_EOF    = 4'd0,
        K_IDENT  = 4'd1,
        K_NUMBER = 4'd2,
        K_ARROW  = 4'd3,
        K_LPAREN = 4'd4,
        K_RPAREN = 4'd5,
        K_LBRACE = 4'd6,
        K_RBRACE = 4'd7,
        K_COMMA  = 4'd8,
        K_DOT    = 4'd9,
        K_SEMI   = 4'd10,
        K_EQUAL  = 4'd11
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] tok_start;
        logic [15:0] tok_end;
        logic        last;
    } t_result;

    localparam logic [7:0] C_UNDERSCORE = 8'h5F;
    localparam logic [7:0] C_SLASH      = 8'h2F;
    localparam logic [7:0] C_NEWLINE    = 8'h0A;
    localparam logic [7:0] C_EQUAL      = 8'h3D;
    localparam logic [7:0] C_GREATER    = 8'h3E;
    localparam logic [7:0] C_LPAREN     = 8'h28;
    localparam logic [7:0] C_RPAREN     = 8'h29;
    localparam logic [7:0] C_LBRACE     = 8'h7B;
    localparam logic [7:0] C_RBRACE     = 8'h7D;
    localparam logic [7:0] C_COMMA      = 8'h2C;
    localparam logic [7:0] C_DOT        = 8'h2E;
    localparam logic [7:0] C_SEMI       = 8'h3B;
    localparam logic [7:0] C_SPACE      = 8'h20;
    localparam logic [7:0] C_TAB        = 8'h09;
    localparam logic [7:0] C_CR         = 8'h0D;

    function automatic logic is_space(input logic [7:0] c);
        return (c == C_SPACE) || (c >= C_TAB && c <= C_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == C_UNDERSCORE);
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            C_LPAREN: k = K_LPAREN;
            C_RPAREN: k = K_RPAREN;
            C_LBRACE: k = K_LBRACE;
            C_RBRACE: k = K_RBRACE;
            C_COMMA:  k = K_COMMA;
            C_DOT:    k = K_DOT;
            C_SEMI:   k = K_SEMI;
            default:  k = K_EOF;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### sv/dsl_token_lexer.sv
// A token is offered on the output in the cycle after the word that ends it is accepted.
// Throughput: one input word per cycle while each word yields at most one token and the
// output is taken; after a word yielding two tokens the input is held until the two-entry
// result queue has drained to one token, draining one token per cycle while it is taken.
// Reset: synchronous active-low i_rst_n returns to idle, clears positions and the queue.
`default_nettype none

module dsl_token_lexer #(
    parameter int POS_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic [0:0]  s_axis_tuser,   // [0] action (1 = end of text)
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] token_start, [31:16] token_end
    output logic [3:0]       m_axis_tuser,   // [3:0] token_kind
    output logic             m_axis_tlast    // last_of_run
);
    import dtl_pkg::*;

    localparam logic [POS_BITS-1:0] PosMax = {POS_BITS{1'b1}};

    t_mode               r_mode, n_mode;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_pstart, n_pstart;
    t_result             r_q [2];
    t_result             n_q0, n_q1;
    logic [1:0]          r_cnt, n_cnt;

    logic                s_fire, m_fire, eot;
    logic [7:0]          c;
    logic [POS_BITS-1:0] pos_inc;
    logic                use_fresh;
    t_mode               f_mode;
    logic                f_set, f_emit;
    t_kind               f_kind;
    logic                a_emit, b_emit;
    t_kind               a_kind, b_kind;
    logic [POS_BITS-1:0] a_end, b_start, b_end;
    t_result             res0, res1;
    logic [1:0]          res_n;

    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign m_fire  = m_axis_tvalid && m_axis_tready;
    assign eot     = s_axis_tuser[0];
    assign c       = s_axis_tdata;
    assign pos_inc = (r_pos == PosMax) ? r_pos : r_pos + 1'b1;

    assign s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {r_q[0].tok_end, r_q[0].tok_start};
    assign m_axis_tuser  = r_q[0].kind;
    assign m_axis_tlast  = r_q[0].last;

    // decode a character seen with no token pending
    always_comb begin
        f_mode = M_IDLE;
        f_set  = 1'b0;
        f_emit = 1'b0;
        f_kind = K_EOF;
        priority if (is_space(c)) begin
            f_mode = M_IDLE;
        end else if (c == C_SLASH) begin
            f_mode = M_SLASH;
            f_set  = 1'b1;
        end else if (is_alpha(c) || c == C_UNDERSCORE) begin
            f_mode = M_IDENT;
            f_set  = 1'b1;
        end else if (is_digit(c)) begin
            f_mode = M_NUMBER;
            f_set  = 1'b1;
        end else if (c == C_EQUAL) begin
            f_mode = M_EQUAL;
            f_set  = 1'b1;
        end else begin
            f_emit = 1'b1;
            f_kind = punct_kind(c);
        end
    end

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_pstart  = r_pstart;
        use_fresh = 1'b0;
        if (s_fire) begin
            if (eot) begin
                n_mode   = M_IDLE;
                n_pos    = '0;
                n_pstart = '0;
            end else begin
                n_pos = pos_inc;
                unique case (r_mode)
                    M_IDENT:   use_fresh = !is_word(c);
                    M_NUMBER:  use_fresh = !is_digit(c);
                    M_EQUAL: begin
                        if (c == C_GREATER) begin
                            n_mode = M_IDLE;
                        end else begin
                            use_fresh = 1'b1;
                        end
                    end
                    M_SLASH: begin
                        if (c == C_SLASH) begin
                            n_mode = M_COMMENT;
                        end else begin
                            use_fresh = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (c == C_NEWLINE) begin
                            n_mode = M_IDLE;
                        end
                    end
                    default:   use_fresh = 1'b1;
                endcase
                if (use_fresh) begin
                    n_mode = f_mode;
                    if (f_set) begin
                        n_pstart = r_pos;
                    end
                end
            end
        end
    end

    // results: pending token first, then the token the word itself starts
    always_comb begin
        a_emit  = 1'b0;
        a_kind  = K_EOF;
        a_end   = r_pos;
        b_emit  = 1'b0;
        b_kind  = K_EOF;
        b_start = r_pos;
        b_end   = r_pos;
        unique case (r_mode)
            M_IDENT: begin
                a_emit = eot || !is_word(c);
                a_kind = K_IDENT;
            end
            M_NUMBER: begin
                a_emit = eot || !is_digit(c);
                a_kind = K_NUMBER;
            end
            M_EQUAL: begin
                a_emit = 1'b1;
                if (!eot && c == C_GREATER) begin
                    a_kind = K_ARROW;
                    a_end  = pos_inc;
                end else begin
                    a_kind = K_EQUAL;
                end
            end
            M_SLASH: begin
                a_emit = eot || (c != C_SLASH);
                a_kind = K_EOF;
            end
            default: a_emit = 1'b0;
        endcase
        if (eot) begin
            b_emit = 1'b1;
            b_kind = K_EOF;
        end else begin
            b_emit = use_fresh && f_emit;
            b_kind = f_kind;
            b_end  = pos_inc;
        end

        res1.kind      = b_kind;
        res1.tok_start = 16'(b_start);
        res1.tok_end   = 16'(b_end);
        res1.last      = 1'b1;
        if (a_emit) begin
            res0.kind      = a_kind;
            res0.tok_start = 16'(r_pstart);
            res0.tok_end   = 16'(a_end);
            res0.last      = !b_emit;
        end else begin
            res0 = res1;
        end
        res_n = {1'b0, a_emit} + {1'b0, b_emit};
    end

    // result queue
    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q[0];
        n_q1  = r_q[1];
        if (s_fire) begin
            n_q0  = res0;
            n_q1  = res1;
            n_cnt = res_n;
        end else if (m_fire) begin
            n_q0  = r_q[1];
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_cnt    <= 2'd0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q0;
        r_q[1] <= n_q1;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !s_axis_tready)
        else $error("input taken with full result queue");

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && eot) |=> (r_pos == '0 && r_mode == M_IDLE && r_pstart == '0))
        else $error("end of text did not clear scan state");

    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && eot) |=> (r_cnt != 2'd0))
        else $error("end of text gave no result");
`endif

endmodule

`default_nettype wire

### bench/dsl_token_lexer_test.sv
`default_nettype none

module dsl_token_lexer_test;
    import dtl_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 1650;
    localparam int RX_LONG_STALL  = 300;

    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_GT    = ">";

    typedef struct {
        logic       eot;
        logic [7:0] ch;
        logic       hold;
    } t_src_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] char_in
    logic [0:0]  s_axis_tuser = '0;   // [0] action (1 = end of text)
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [15:0] token_start, [31:16] token_end
    logic [3:0]  m_axis_tuser;        // [3:0] token_kind
    logic        m_axis_tlast;

    dsl_token_lexer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_src_word   src_q[$];
    t_result     token_q[$];
    t_result     run_q[$];
    t_result     want;
    t_mode       lex_mode = M_IDLE;
    logic [15:0] next_pos = '0;
    logic [15:0] tok_begin = '0;
    bit          in_fire = 1'b0;
    bit          out_fire = 1'b0;
    bit          hold_next = 1'b0;
    bit          stall_done = 1'b0;
    int          in_count = 0;
    int          total_words = 0;
    int          fail_cnt = 0;
    int          idle_cycles = 0;
    int          send_gap = 0;
    int          rx_gap = 0;
    int          stall_left = 0;
    logic        calm;

    logic [7:0] blank_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    logic [7:0] mark_set  [7] = '{"(", ")", "{", "}", ",", ".", ";"};

    assign calm = ((in_count / 256) % 4) == 2;

    function automatic bit blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit numeral(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic bit letter(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic bit word_char(input logic [7:0] c);
        return letter(c) || numeral(c) || c == CH_UNDER;
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] p);
        return (p == 16'hFFFF) ? p : p + 16'd1;
    endfunction

    function automatic t_kind mark_kind(input logic [7:0] c);
        case (c)
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            ",": return K_COMMA;
            ".": return K_DOT;
            ";": return K_SEMI;
            default: return K_EOF;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_token(input t_kind k, input logic [15:0] s, input logic [15:0] e);
        t_result r;
        r.kind = k;
        r.tok_start = s;
        r.tok_end = e;
        r.last = 1'b0;
        run_q.push_back(r);
    endtask

    task automatic open_token(input logic [7:0] c, input logic [15:0] p);
        if (blank(c)) begin
            lex_mode = M_IDLE;
        end else if (c == CH_SLASH) begin
            lex_mode = M_SLASH;
            tok_begin = p;
        end else if (letter(c) || c == CH_UNDER) begin
            lex_mode = M_IDENT;
            tok_begin = p;
        end else if (numeral(c)) begin
            lex_mode = M_NUMBER;
            tok_begin = p;
        end else if (c == CH_EQ) begin
            lex_mode = M_EQUAL;
            tok_begin = p;
        end else begin
            lex_mode = M_IDLE;
            note_token(mark_kind(c), p, bump(p));
        end
    endtask

    task automatic scan_word(input logic is_eot, input logic [7:0] c);
        logic [15:0] p;
        p = next_pos;
        run_q.delete();
        if (is_eot) begin
            case (lex_mode)
                M_IDENT:  note_token(K_IDENT, tok_begin, p);
                M_NUMBER: note_token(K_NUMBER, tok_begin, p);
                M_EQUAL:  note_token(K_EQUAL, tok_begin, p);
                M_SLASH:  note_token(K_EOF, tok_begin, p);
                default: ;
            endcase
            note_token(K_EOF, p, p);
            lex_mode = M_IDLE;
            next_pos = '0;
            tok_begin = '0;
        end else begin
            case (lex_mode)
                M_IDENT: if (!word_char(c)) begin
                    note_token(K_IDENT, tok_begin, p);
                    open_token(c, p);
                end
                M_NUMBER: if (!numeral(c)) begin
                    note_token(K_NUMBER, tok_begin, p);
                    open_token(c, p);
                end
                M_EQUAL: if (c == CH_GT) begin
                    note_token(K_ARROW, tok_begin, bump(p));
                    lex_mode = M_IDLE;
                end else begin
                    note_token(K_EQUAL, tok_begin, p);
                    open_token(c, p);
                end
                M_SLASH: if (c == CH_SLASH) begin
                    lex_mode = M_COMMENT;
                end else begin
                    note_token(K_EOF, tok_begin, p);
                    open_token(c, p);
                end
                M_COMMENT: if (c == CH_LF) begin
                    lex_mode = M_IDLE;
                end
                default: open_token(c, p);
            endcase
            next_pos = bump(p);
        end
        if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i]) token_q.push_back(run_q[i]);
    endtask

    task automatic put_char(input logic [7:0] c);
        t_src_word w;
        w.eot = 1'b0;
        w.ch = c;
        w.hold = hold_next;
        hold_next = 1'b0;
        src_q.push_back(w);
    endtask

    task automatic put_eot();
        t_src_word w;
        w.eot = 1'b1;
        w.ch = 8'($urandom_range(0, 255));
        w.hold = hold_next;
        hold_next = 1'b0;
        src_q.push_back(w);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    function automatic logic [7:0] rand_head();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_tail();
        if ($urandom_range(0, 3) == 0) return 8'h30 + 8'($urandom_range(0, 9));
        return rand_head();
    endfunction

    task automatic put_random_chunk();
        int r;
        int len;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            put_char(rand_head());
            len = $urandom_range(0, 7);
            repeat (len) put_char(rand_tail());
        end else if (r < 40) begin
            len = $urandom_range(1, 6);
            repeat (len) put_char(8'h30 + 8'($urandom_range(0, 9)));
        end else if (r < 47) begin
            put_text("=>");
        end else if (r < 52) begin
            put_char(CH_EQ);
        end else if (r < 65) begin
            put_char(mark_set[$urandom_range(0, 6)]);
        end else if (r < 78) begin
            len = $urandom_range(1, 3);
            repeat (len) put_char(blank_set[$urandom_range(0, 5)]);
        end else if (r < 83) begin
            put_text("//");
            len = $urandom_range(0, 8);
            repeat (len) begin
                c = 8'($urandom_range(0, 255));
                put_char(c == CH_LF ? 8'h20 : c);
            end
            if ($urandom_range(0, 4) != 0) put_char(CH_LF);
        end else if (r < 86) begin
            put_char(CH_SLASH);
        end else if (r < 89) begin
            put_eot();
        end else begin
            put_char(8'($urandom_range(0, 255)));
        end
    endtask

    // driver: hold the word until taken, then idle or advance
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end else if (src_q.size() > 0 && !(src_q[0].hold && token_q.size() > 0)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= src_q[0].ch;
                s_axis_tuser <= src_q[0].eot;
                send_gap = calm ? 0 : pick_gap();
                void'(src_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!stall_done && in_count >= 400) begin
            stall_done = 1'b1;
            stall_left = RX_LONG_STALL - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap--;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire) begin
            scan_word(s_axis_tuser[0], s_axis_tdata);
            in_count++;
        end
        if (out_fire) begin
            if (token_q.size() == 0) begin
                $error("unexpected token: kind %0d start %0d end %0d", m_axis_tuser,
                       m_axis_tdata[15:0], m_axis_tdata[31:16]);
                fail_cnt++;
            end else begin
                want = token_q.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tdata[15:0] !== want.tok_start) begin
                    $error("token_start: expected %0d, got %0d", want.tok_start,
                           m_axis_tdata[15:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[31:16] !== want.tok_end) begin
                    $error("token_end: expected %0d, got %0d", want.tok_end,
                           m_axis_tdata[31:16]);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
        idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int base;
        put_text("_Z9=>12{");
        put_text("(),.;}");
        put_char(CH_EQ);
        put_char(8'hFF);
        put_char(8'h00);
        put_text("/x//c");
        put_char(CH_LF);
        put_eot();

        hold_next = 1'b1;
        base = src_q.size();
        while (src_q.size() - base < RANDOM_WORDS) begin
            if (src_q.size() - base >= RANDOM_WORDS / 2 &&
                src_q.size() - base < RANDOM_WORDS / 2 + 8)
                hold_next = 1'b1;
            put_random_chunk();
        end
        put_eot();

        hold_next = 1'b1;
        put_text("abcdefghij=>1;");
        put_eot();
        put_char("x");
        put_eot();
        total_words = src_q.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (in_count < total_words) @(posedge i_clk);
        while (token_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && token_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
